[rtl/isdi_pkg.sv]
// ----------------------------------------------------------------------------
// isdi_pkg
// Types, register indexes and reset values shared by the spring-damper
// integrator, its multiply unit and its checker.
// ----------------------------------------------------------------------------
package isdi_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;
	localparam int COEF_W     = 24;
	localparam int KICK_W     = 31;
	localparam int TIME_W     = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LIN_STIFFNESS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_DAMPING   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_STIFFNESS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_DAMPING   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIN_KICK      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ANG_KICK      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN      = 3'd6;

	localparam logic [COEF_W-1:0] RST_LIN_STIFFNESS = 24'd65829;
	localparam logic [COEF_W-1:0] RST_LIN_DAMPING   = 24'd4023;
	localparam logic [COEF_W-1:0] RST_ANG_STIFFNESS = 24'd110933;
	localparam logic [COEF_W-1:0] RST_ANG_DAMPING   = 24'd7680;
	localparam logic [KICK_W-1:0] RST_LIN_KICK      = 31'd4718592;
	localparam logic [KICK_W-1:0] RST_ANG_KICK      = 31'd19660800;
	localparam logic [TIME_W-1:0] RST_COOLDOWN      = 16'd7209;

	typedef struct packed {
		logic              action;
		logic [TIME_W-1:0] dt;
		logic              fire_request;
	} step_t;

	typedef struct packed {
		logic signed [31:0] pos_offset;
		logic signed [31:0] lin_velocity;
		logic signed [31:0] ang_offset;
		logic signed [31:0] ang_velocity;
		logic               fired;
		logic [15:0]        shot_count;
	} result_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_XK,
		ST_VC,
		ST_AD,
		ST_VD,
		ST_DONE
	} seq_state_t;

	typedef enum logic [1:0] {
		MP_IDLE,
		MP_HI,
		MP_SAT
	} mul_phase_t;

	typedef struct packed {
		logic start;
		logic sh16;
	} mul_req_t;

endpackage

[rtl/isdi_stream_if.sv]
// ----------------------------------------------------------------------------
// isdi_stream_if
// Valid/ready stream channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface isdi_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/isdi_mul.sv]
// ----------------------------------------------------------------------------
// isdi_mul
// Shared signed-by-unsigned multiplier: (a * b) >>> 8 or 16, saturated to
// the state width. The signed operand is split in two halves, so one product
// takes a low pass, a high pass and a saturation pass.
// ----------------------------------------------------------------------------
module isdi_mul
	import isdi_pkg::*;
#(
	parameter int W = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mul_req_t            req,
	input  logic signed [W-1:0] op_a,
	input  logic [COEF_W-1:0]   op_b,
	output logic                done,
	output logic signed [W-1:0] res
);

	localparam int LO_W = W / 2;
	localparam int HI_W = W - LO_W;
	localparam int OPW  = HI_W + 1;
	localparam int PW   = OPW + COEF_W + 1;
	localparam int ACCW = W + COEF_W + 1;

	localparam logic signed [ACCW-1:0] SMAX_A = {{(ACCW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [ACCW-1:0] SMIN_A = {{(ACCW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [W-1:0]    SMAX   = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0]    SMIN   = {1'b1, {(W-1){1'b0}}};

	mul_phase_t                 phase_q;
	logic signed [HI_W-1:0]     a_q;
	logic [COEF_W-1:0]          b_q;
	logic                       sh16_q;
	logic signed [ACCW-1:0]     acc_q;
	logic                       done_q;
	logic signed [W-1:0]        res_q;

	logic signed [OPW-1:0]      mul_x;
	logic signed [COEF_W:0]     mul_y;
	logic signed [PW-1:0]       prod;
	logic signed [ACCW-1:0]     shifted;

	always_comb begin
		if (phase_q == MP_HI) begin
			mul_x = {a_q[HI_W-1], a_q};
			mul_y = {1'b0, b_q};
		end else begin
			mul_x = {{(OPW-LO_W){1'b0}}, op_a[LO_W-1:0]};
			mul_y = {1'b0, op_b};
		end
		prod    = mul_x * mul_y;
		shifted = sh16_q ? (acc_q >>> 16) : (acc_q >>> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= MP_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				MP_IDLE: begin
					if (req.start) phase_q <= MP_HI;
				end
				MP_HI:   phase_q <= MP_SAT;
				MP_SAT: begin
					phase_q <= MP_IDLE;
					done_q  <= 1'b1;
				end
				default: phase_q <= MP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (phase_q)
			MP_IDLE: begin
				if (req.start) begin
					a_q    <= op_a[W-1:LO_W];
					b_q    <= op_b;
					sh16_q <= req.sh16;
					acc_q  <= ACCW'(prod);
				end
			end
			MP_HI: acc_q <= acc_q + (ACCW'(prod) <<< LO_W);
			MP_SAT: begin
				if (shifted > SMAX_A)      res_q <= SMAX;
				else if (shifted < SMIN_A) res_q <= SMIN;
				else                       res_q <= shifted[W-1:0];
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

[rtl/impulse_spring_damper_integrator.sv]
// ----------------------------------------------------------------------------
// impulse_spring_damper_integrator
// Linear and angular spring-damper oscillators kicked by shots, with a shot
// cooldown timer, advanced one semi-implicit Euler step per input beat.
//
//   Channel   Direction  Beat contents
//   step      in         action, dt, fire_request
//   result    out        pos_offset, lin_velocity, ang_offset, ang_velocity,
//                        fired, shot_count
//   cfg_*     in         register write: enable, index, data (no handshake)
//
// A step runs through the accepting cycle, the prep state for the timer, kick
// and reset, eight products on the shared multiplier, and the load of the
// result register, which waits while a stalled result still holds it.
// Asynchronous active-low reset loads the register defaults and clears state.
// A stalled result holds in its register; step is taken again once the
// result register is free or being emptied.
// ----------------------------------------------------------------------------
module impulse_spring_damper_integrator
	import isdi_pkg::*;
#(
	parameter int STATE_WIDTH = 32,
	parameter int COUNT_WIDTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	isdi_stream_if.sink           step,
	isdi_stream_if.source         result
);

	localparam int W  = STATE_WIDTH;
	localparam int KW = ((W > KICK_W) ? W : KICK_W) + 2;

	localparam logic signed [W+1:0] SMAX2 = {3'b000, {(W-1){1'b1}}};
	localparam logic signed [W+1:0] SMIN2 = {3'b111, {(W-1){1'b0}}};
	localparam logic signed [KW-1:0] SMAXK = {{(KW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic signed [KW-1:0] SMINK = {{(KW-W+1){1'b1}}, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] v);
		if (v > SMAX2)      return SMAX;
		else if (v < SMIN2) return SMIN;
		else                return v[W-1:0];
	endfunction

	function automatic logic signed [W-1:0] satk(input logic signed [KW-1:0] v);
		if (v > SMAXK)      return SMAX;
		else if (v < SMINK) return SMIN;
		else                return v[W-1:0];
	endfunction

	// Configuration registers.
	logic [COEF_W-1:0] lin_k_q, lin_c_q, ang_k_q, ang_c_q;
	logic [KICK_W-1:0] lin_kick_q, ang_kick_q;
	logic [TIME_W-1:0] cooldown_q;

	// Oscillator and shot state.
	logic signed [W-1:0]    pos_q, vel_q, ang_q, rate_q;
	logic [TIME_W-1:0]      timer_q;
	logic [COUNT_WIDTH-1:0] shots_q;
	logic                   fired_q;

	// Sequencer and scratch values.
	seq_state_t          state_q, state_d;
	logic                osc_q;
	logic                start_q, start_d;
	step_t               step_q;
	logic signed [W-1:0] p1_q, acc_a_q;

	result_t out_q;
	logic    out_valid_q;
	logic    out_free;
	logic    out_load;

	mul_req_t            mreq;
	logic signed [W-1:0] m_a;
	logic [COEF_W-1:0]   m_b;
	logic                m_done;
	logic signed [W-1:0] m_res;

	// Prep cycle terms and the selected oscillator's position and velocity.
	logic [TIME_W-1:0]   timer_dec;
	logic                fire_now;
	logic signed [W-1:0] vel_kicked, rate_kicked;
	logic signed [W-1:0] cur_x, cur_v;

	isdi_mul #(.W(W)) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.op_a  (m_a),
		.op_b  (m_b),
		.done  (m_done),
		.res   (m_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lin_k_q    <= RST_LIN_STIFFNESS;
			lin_c_q    <= RST_LIN_DAMPING;
			ang_k_q    <= RST_ANG_STIFFNESS;
			ang_c_q    <= RST_ANG_DAMPING;
			lin_kick_q <= RST_LIN_KICK;
			ang_kick_q <= RST_ANG_KICK;
			cooldown_q <= RST_COOLDOWN;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LIN_STIFFNESS: lin_k_q    <= cfg_wdata[COEF_W-1:0];
				REG_LIN_DAMPING:   lin_c_q    <= cfg_wdata[COEF_W-1:0];
				REG_ANG_STIFFNESS: ang_k_q    <= cfg_wdata[COEF_W-1:0];
				REG_ANG_DAMPING:   ang_c_q    <= cfg_wdata[COEF_W-1:0];
				REG_LIN_KICK:      lin_kick_q <= cfg_wdata[KICK_W-1:0];
				REG_ANG_KICK:      ang_kick_q <= cfg_wdata[KICK_W-1:0];
				REG_COOLDOWN:      cooldown_q <= cfg_wdata[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (step.valid) state_d = ST_PREP;
			ST_PREP: state_d = ST_XK;
			ST_XK:   if (m_done) state_d = ST_VC;
			ST_VC:   if (m_done) state_d = ST_AD;
			ST_AD:   if (m_done) state_d = ST_VD;
			ST_VD:   if (m_done) state_d = osc_q ? ST_DONE : ST_XK;
			ST_DONE: if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs of the sequencer: handshakes and multiplier operands.
	always_comb begin
		out_free = !out_valid_q || result.ready;
		out_load = (state_q == ST_DONE) && out_free;
		step.ready = (state_q == ST_IDLE);
		start_d = (state_d != state_q) &&
			(state_d == ST_XK || state_d == ST_VC || state_d == ST_AD || state_d == ST_VD);
		cur_x = osc_q ? ang_q : pos_q;
		cur_v = osc_q ? rate_q : vel_q;
		mreq.start = start_q;
		mreq.sh16  = 1'b0;
		m_a = cur_x;
		m_b = osc_q ? ang_k_q : lin_k_q;
		case (state_q)
			ST_VC: begin
				m_a = cur_v;
				m_b = osc_q ? ang_c_q : lin_c_q;
			end
			ST_AD: begin
				m_a = acc_a_q;
				m_b = {{(COEF_W-TIME_W){1'b0}}, step_q.dt};
				mreq.sh16 = 1'b1;
			end
			ST_VD: begin
				m_a = cur_v;
				m_b = {{(COEF_W-TIME_W){1'b0}}, step_q.dt};
				mreq.sh16 = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		timer_dec   = (timer_q > step_q.dt) ? (timer_q - step_q.dt) : '0;
		fire_now    = step_q.fire_request && (timer_dec == '0);
		vel_kicked  = satk(KW'(vel_q) - $signed({{(KW-KICK_W){1'b0}}, lin_kick_q}));
		rate_kicked = satk(KW'(rate_q) - $signed({{(KW-KICK_W){1'b0}}, ang_kick_q}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			start_q <= 1'b0;
			osc_q   <= 1'b0;
			pos_q   <= '0;
			vel_q   <= '0;
			ang_q   <= '0;
			rate_q  <= '0;
			timer_q <= '0;
			shots_q <= '0;
			fired_q <= 1'b0;
		end else begin
			state_q <= state_d;
			start_q <= start_d;
			case (state_q)
				ST_PREP: begin
					osc_q   <= 1'b0;
					fired_q <= fire_now;
					timer_q <= fire_now ? cooldown_q : timer_dec;
					if (step_q.action) begin
						pos_q   <= '0;
						vel_q   <= '0;
						ang_q   <= '0;
						rate_q  <= '0;
						shots_q <= '0;
					end else if (fire_now) begin
						vel_q  <= vel_kicked;
						rate_q <= rate_kicked;
						if (shots_q != '1) shots_q <= shots_q + 1'b1;
					end
				end
				ST_AD: begin
					if (m_done) begin
						if (osc_q) rate_q <= sat2((W+2)'(rate_q) + (W+2)'(m_res));
						else       vel_q  <= sat2((W+2)'(vel_q) + (W+2)'(m_res));
					end
				end
				ST_VD: begin
					if (m_done) begin
						if (osc_q) ang_q <= sat2((W+2)'(ang_q) + (W+2)'(m_res));
						else       pos_q <= sat2((W+2)'(pos_q) + (W+2)'(m_res));
						osc_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Scratch products; a = -(k*x) - (c*v) is formed as the second one lands.
	always_ff @(posedge clk) begin
		if (step.valid && step.ready) step_q <= step.data;
		if (m_done && state_q == ST_XK) p1_q <= m_res;
		if (m_done && state_q == ST_VC) acc_a_q <= sat2(-(W+2)'(p1_q) - (W+2)'(m_res));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.pos_offset   <= 32'(pos_q);
			out_q.lin_velocity <= 32'(vel_q);
			out_q.ang_offset   <= 32'(ang_q);
			out_q.ang_velocity <= 32'(rate_q);
			out_q.fired        <= fired_q;
			out_q.shot_count   <= 16'(shots_q);
		end
	end

	assign result.valid = out_valid_q;
	assign result.data  = out_q;

endmodule

[rtl/isdi_checker.sv]
// ----------------------------------------------------------------------------
// isdi_checker
// Port-level checks on the spring-damper integrator, bound to the top level.
// ----------------------------------------------------------------------------
module isdi_checker
	import isdi_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    step_valid,
	input logic    step_ready,
	input logic    res_valid,
	input logic    res_ready,
	input result_t res_data
);

	// A stalled result beat stays offered.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result beat dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_data))
		else $error("result payload changed while stalled");

	// The block works on one step at a time.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !step_ready)
		else $error("step taken while a step is in progress");

	// A step's result cannot appear right after its acceptance.
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		step_valid && step_ready |=> !$rose(res_valid))
		else $error("result appeared one cycle after a step beat");

endmodule

bind impulse_spring_damper_integrator isdi_checker u_isdi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.step_valid(step.valid),
	.step_ready(step.ready),
	.res_valid (result.valid),
	.res_ready (result.ready),
	.res_data  (result.data)
);
